/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the checker files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge, suspended while reset is asserted
`define JDQ_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("joystick qualifier check failed");

// checked on every clock edge, reset included
`define JDQ_ASSERT_ALWAYS(label, clk, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("joystick qualifier check failed");

`endif

/* hdl/jdq_pkg.sv */
// ----------------------------------------------------------------------------
// jdq_pkg
// widths, codes and reset values of the joystick direction qualifier
// ----------------------------------------------------------------------------
package jdq_pkg;

	localparam int W_AXIS   = 8;
	localparam int W_REMOTE = 2;
	localparam int W_DIR    = 3;
	localparam int W_DZ     = 7;
	localparam int W_CNT    = 4;
	localparam int W_CFGIDX = 2;
	localparam int W_CFGDAT = 7;

	typedef logic [W_DIR-1:0]    dir_t;
	typedef logic [W_REMOTE-1:0] remote_t;
	typedef logic [W_CNT-1:0]    cnt_t;
	typedef logic [W_CFGIDX-1:0] cfg_idx_t;

	localparam dir_t DIR_MIDDLE = 3'd0;
	localparam dir_t DIR_UP     = 3'd1;
	localparam dir_t DIR_DOWN   = 3'd2;
	localparam dir_t DIR_LEFT   = 3'd3;
	localparam dir_t DIR_RIGHT  = 3'd4;

	localparam remote_t REMOTE_STOP  = 2'd0;
	localparam remote_t REMOTE_LEFT  = 2'd1;
	localparam remote_t REMOTE_RIGHT = 2'd2;

	localparam cfg_idx_t CFG_DEAD_ZONE     = 2'd0;
	localparam cfg_idx_t CFG_HOLD_TICKS    = 2'd1;
	localparam cfg_idx_t CFG_REPEAT_PERIOD = 2'd2;

	localparam logic [W_DZ-1:0] DEAD_ZONE_RST     = 7'd60;
	localparam cnt_t            HOLD_TICKS_RST    = 4'd2;
	localparam cnt_t            REPEAT_PERIOD_RST = 4'd10;

	localparam logic [W_AXIS+1:0] CENTER  = 10'd127;
	localparam cnt_t              SAT_MAX = 4'd15;

endpackage

/* hdl/joystick_direction_qualifier.sv */
// ----------------------------------------------------------------------------
// joystick_direction_qualifier
// Classifies each joystick X/Y sample as middle, up, down, left or right
// against a programmable dead zone, keeps per-direction hold counters and
// picks an action from the counters and the remote command, with auto-repeat
// on up and down. One sample is taken per clock while in_stall is low; a sample
// is classified and the hold counters updated from the input register, and its
// result then sits in the output register until transferred, so the throughput
// is one item per cycle while the output is not stalled. The hold counters are
// the only loop from one item to the next. Configuration writes are always
// ready and should be issued only while no item is in flight.
// ----------------------------------------------------------------------------
module joystick_direction_qualifier
	import jdq_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,

	input  logic                in_valid,
	output logic                in_stall,
	input  logic [W_AXIS-1:0]   joy_x,
	input  logic [W_AXIS-1:0]   joy_y,
	input  logic [W_REMOTE-1:0] remote_dir,

	output logic                out_valid,
	input  logic                out_stall,
	output logic [W_DIR-1:0]    action,
	output logic [W_DIR-1:0]    stick_dir,

	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [W_CFGIDX-1:0] cfg_index,
	input  logic [W_CFGDAT-1:0] cfg_data
);

	logic              valid_s1;
	logic [W_AXIS-1:0] joy_x_s1;
	logic [W_AXIS-1:0] joy_y_s1;
	remote_t           remote_dir_s1;

	logic              valid_s2;
	dir_t              action_s2;
	dir_t              stick_dir_s2;

	logic [W_DZ-1:0]   dead_zone_q;
	cnt_t              hold_ticks_q;
	cnt_t              repeat_period_q;

	cnt_t middle_count_q, up_count_q, down_count_q, left_count_q, right_count_q;
	cnt_t middle_next, up_next, down_next, left_next, right_next;

	logic                   s2_free;
	logic                   advance;
	logic signed [W_AXIS+1:0] dx, dy, ndx, ndy, dz, ndz;
	dir_t                   dir;
	dir_t                   act;

	function automatic cnt_t sat_inc(input cnt_t c);
		sat_inc = (c == SAT_MAX) ? SAT_MAX : c + 4'd1;
	endfunction

	function automatic cnt_t mod_inc(input cnt_t c, input cnt_t period);
		logic [W_CNT:0] n;
		n = {1'b0, c} + 5'd1;
		mod_inc = (n >= {1'b0, period}) ? '0 : n[W_CNT-1:0];
	endfunction

	assign cfg_ready = 1'b1;

	assign s2_free  = !valid_s2 || !out_stall;
	assign advance  = valid_s1 && s2_free;
	assign in_stall = valid_s1 && !s2_free;

	assign out_valid = valid_s2;
	assign action    = action_s2;
	assign stick_dir = stick_dir_s2;

	// centered axes and dead zone
	always_comb begin
		dx  = signed'({2'b00, joy_x_s1}) - signed'(CENTER);
		dy  = signed'({2'b00, joy_y_s1}) - signed'(CENTER);
		ndx = -dx;
		ndy = -dy;
		dz  = signed'({3'b000, dead_zone_q});
		ndz = -dz;
	end

	always_comb begin
		dir = DIR_MIDDLE;
		if (dx > dz && dx > dy && dx > ndy) begin
			dir = DIR_RIGHT;
		end else if (dx < ndz && dx < dy && dx < ndy) begin
			dir = DIR_LEFT;
		end
		if (dy > dz && dy > dx && dy > ndx) begin
			dir = DIR_UP;
		end else if (dy < ndz && dy < dx && dy < ndx) begin
			dir = DIR_DOWN;
		end
	end

	always_comb begin
		middle_next = (dir == DIR_MIDDLE) ? sat_inc(middle_count_q) : '0;
		up_next     = (dir == DIR_UP) ? mod_inc(up_count_q, repeat_period_q) : '0;
		down_next   = (dir == DIR_DOWN) ? mod_inc(down_count_q, repeat_period_q) : '0;
		left_next   = (dir == DIR_LEFT) ? sat_inc(left_count_q) : '0;
		right_next  = (dir == DIR_RIGHT) ? sat_inc(right_count_q) : '0;
	end

	// later rules override earlier ones
	always_comb begin
		act = DIR_MIDDLE;
		if (up_next == hold_ticks_q && remote_dir_s1 == REMOTE_STOP) begin
			act = DIR_UP;
		end
		if (down_next == hold_ticks_q && remote_dir_s1 == REMOTE_STOP) begin
			act = DIR_DOWN;
		end
		if (left_next >= hold_ticks_q || remote_dir_s1 == REMOTE_LEFT) begin
			act = DIR_LEFT;
		end
		if (right_next >= hold_ticks_q || remote_dir_s1 == REMOTE_RIGHT) begin
			act = DIR_RIGHT;
		end
		if (middle_next >= hold_ticks_q && remote_dir_s1 == REMOTE_STOP) begin
			act = DIR_MIDDLE;
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			joy_x_s1      <= joy_x;
			joy_y_s1      <= joy_y;
			remote_dir_s1 <= remote_dir;
		end
	end

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			action_s2    <= act;
			stick_dir_s2 <= dir;
		end
	end

	// hold counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			middle_count_q <= '0;
			up_count_q     <= '0;
			down_count_q   <= '0;
			left_count_q   <= '0;
			right_count_q  <= '0;
		end else if (advance) begin
			middle_count_q <= middle_next;
			up_count_q     <= up_next;
			down_count_q   <= down_next;
			left_count_q   <= left_next;
			right_count_q  <= right_next;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dead_zone_q     <= DEAD_ZONE_RST;
			hold_ticks_q    <= HOLD_TICKS_RST;
			repeat_period_q <= REPEAT_PERIOD_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_DEAD_ZONE:     dead_zone_q     <= cfg_data;
				CFG_HOLD_TICKS:    hold_ticks_q    <= cfg_data[W_CNT-1:0];
				CFG_REPEAT_PERIOD: repeat_period_q <= cfg_data[W_CNT-1:0];
				default: begin
				end
			endcase
		end
	end

endmodule

/* hdl/jdq_checker.sv */
// ----------------------------------------------------------------------------
// jdq_checker
// port-level checks of the joystick direction qualifier, bound to the top
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module jdq_checker
	import jdq_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_stall,
	input logic             out_valid,
	input logic             out_stall,
	input logic [W_DIR-1:0] action,
	input logic [W_DIR-1:0] stick_dir
);

	// input only backs up behind a held result
	`JDQ_ASSERT_ALWAYS(a_stall_needs_result, clk, (in_stall |-> out_valid))

	// a fresh result follows an input transfer through the input and result registers
	`JDQ_ASSERT(a_result_from_input, clk, arst_n, ($rose(out_valid) |-> $past(in_valid && !in_stall, 2)))

	`JDQ_ASSERT(a_out_valid_held, clk, arst_n, (out_valid && out_stall |=> out_valid))

	`JDQ_ASSERT(a_out_payload_held, clk, arst_n, (out_valid && out_stall |=> $stable(action) && $stable(stick_dir)))

endmodule

bind joystick_direction_qualifier jdq_checker u_jdq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.action    (action),
	.stick_dir (stick_dir)
);
